@@ sv/vnc_pkg.sv @@
// Shared types, constants and schedule tables of the nonlinear channel core.
package vnc_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int W = SAMPLE_WIDTH;
  localparam int TAPS = 5;
  localparam int FRAC = 15;
  localparam int XW = 20;
  localparam int PW = 2 * XW + 1;
  localparam int CW = 16;
  localparam int TW = XW + CW;
  localparam int AW = TW + 8;
  localparam int NOPS = 19;
  localparam int OPW = 5;
  localparam int CNTW = 3;
  localparam logic signed [XW-1:0] ONE_Q15 = XW'(32768);

  typedef logic signed [W-1:0] samp_t;

  typedef struct packed {
    logic signed [W-1:0] re;
    logic signed [W-1:0] im;
  } csamp_t;

  typedef struct packed {
    logic signed [XW-1:0] re;
    logic signed [XW-1:0] im;
  } cop_t;

  typedef struct packed {
    logic             pass;
    csamp_t [TAPS:0]  x;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef enum logic [3:0] {
    SRC_X0, SRC_X1, SRC_X2, SRC_X3, SRC_X4, SRC_X5,
    SRC_ONE, SRC_SQ1, SRC_S5, SRC_C5
  } src_t;

  typedef enum logic [1:0] {DST_NONE, DST_SQ1, DST_S5, DST_C5} dst_t;

  typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_RND, ST_ACC, ST_FIN} state_t;

  typedef struct packed {
    state_t state;
  } back_stat_t;

  // First operand of each scheduled complex product.
  function automatic src_t op_a(input logic [OPW-1:0] op);
    src_t s;
    case (op)
      5'd0: s = SRC_X0;
      5'd1: s = SRC_X1;
      5'd2: s = SRC_X2;
      5'd3: s = SRC_X3;
      5'd4: s = SRC_X4;
      5'd5: s = SRC_X5;
      5'd6, 5'd7, 5'd8, 5'd9, 5'd10: s = SRC_X0;
      5'd11, 5'd12: s = SRC_X1;
      5'd13: s = SRC_X3;
      5'd14: s = SRC_X5;
      5'd15: s = SRC_S5;
      5'd16, 5'd17: s = SRC_X0;
      5'd18: s = SRC_X2;
      default: s = SRC_X0;
    endcase
    return s;
  endfunction

  // Second operand; the linear taps multiply by exactly one.
  function automatic src_t op_b(input logic [OPW-1:0] op);
    src_t s;
    case (op)
      5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5: s = SRC_ONE;
      5'd6: s = SRC_X1;
      5'd7: s = SRC_X2;
      5'd8: s = SRC_X3;
      5'd9: s = SRC_X4;
      5'd10: s = SRC_X5;
      5'd11: s = SRC_X3;
      5'd12: s = SRC_X1;
      5'd13: s = SRC_SQ1;
      5'd14, 5'd15: s = SRC_X5;
      5'd16: s = SRC_C5;
      5'd17: s = SRC_X0;
      5'd18: s = SRC_X2;
      default: s = SRC_ONE;
    endcase
    return s;
  endfunction

  function automatic dst_t op_dst(input logic [OPW-1:0] op);
    dst_t d;
    case (op)
      5'd12: d = DST_SQ1;
      5'd14: d = DST_S5;
      5'd15: d = DST_C5;
      default: d = DST_NONE;
    endcase
    return d;
  endfunction

  // Q1.15 weights; x0*x2 carries both of its weights summed.
  function automatic logic signed [CW-1:0] op_coef(input logic [OPW-1:0] op);
    logic signed [CW-1:0] c;
    case (op)
      5'd0: c = 16'sd29491;
      5'd1: c = 16'sd3277;
      5'd2: c = 16'sd2949;
      5'd3: c = 16'sd2621;
      5'd4: c = 16'sd1638;
      5'd5: c = 16'sd983;
      5'd6: c = 16'sd426;
      5'd7: c = 16'sd1048;
      5'd8: c = 16'sd328;
      5'd9: c = 16'sd655;
      5'd10: c = 16'sd721;
      5'd11: c = 16'sd295;
      5'd12: c = 16'sd328;
      5'd13: c = 16'sd623;
      5'd16: c = 16'sd328;
      5'd17: c = 16'sd1638;
      5'd18: c = 16'sd1638;
      default: c = 16'sd0;
    endcase
    return c;
  endfunction

endpackage

@@ sv/vnc_in_if.sv @@
// Input sample channel: valid, ready and one complex input word.
interface vnc_in_if;
  logic              valid;
  logic              ready;
  vnc_pkg::samp_t    sample_re;
  vnc_pkg::samp_t    sample_im;
  modport source (output valid, output sample_re, output sample_im, input ready);
  modport sink (input valid, input sample_re, input sample_im, output ready);
endinterface

@@ sv/vnc_out_if.sv @@
// Result sample channel: valid, ready and one complex output word.
interface vnc_out_if;
  logic              valid;
  logic              ready;
  vnc_pkg::samp_t    out_re;
  vnc_pkg::samp_t    out_im;
  modport source (output valid, output out_re, output out_im, input ready);
  modport sink (input valid, input out_re, input out_im, output ready);
endinterface

@@ sv/vnc_fifo.sv @@
// Two-entry job queue between the front and back parts.
module vnc_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  vnc_pkg::job_t       din,
  input  logic                pop,
  output vnc_pkg::job_t       dout,
  output vnc_pkg::fifo_stat_t stat
);

  vnc_pkg::job_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  assign dout = mem_r[rd_ptr_r];
  assign stat.full = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);

endmodule

@@ sv/vnc_front.sv @@
// Front part: accepts samples, keeps the history and warm-up count, classifies jobs.
module vnc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  vnc_in_if.sink              in_s,
  input  vnc_pkg::fifo_stat_t fstat,
  output logic                push,
  output vnc_pkg::job_t       job
);

  vnc_pkg::csamp_t                 hist_r [vnc_pkg::TAPS];
  logic [vnc_pkg::CNTW-1:0]        cnt_r, cnt_nxt;
  logic                            en_r;
  vnc_pkg::csamp_t                 cur;

  assign in_s.ready = !fstat.full;
  assign push = in_s.valid && !fstat.full;
  assign cur.re = in_s.sample_re;
  assign cur.im = in_s.sample_im;

  always_comb begin
    job.pass = !en_r || (cnt_r < vnc_pkg::CNTW'(vnc_pkg::TAPS));
    job.x[0] = cur;
    for (int k = 1; k <= vnc_pkg::TAPS; k++) begin
      job.x[k] = hist_r[k-1];
    end
    cnt_nxt = (cnt_r < vnc_pkg::CNTW'(vnc_pkg::TAPS)) ? cnt_r + 1'b1 : cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= 1'b1;
      cnt_r <= '0;
      for (int k = 0; k < vnc_pkg::TAPS; k++) begin
        hist_r[k] <= '0;
      end
    end else begin
      if (cfg_we) begin
        en_r <= cfg_wdata;
      end
      if (push) begin
        cnt_r <= cnt_nxt;
        hist_r[0] <= cur;
        for (int k = 1; k < vnc_pkg::TAPS; k++) begin
          hist_r[k] <= hist_r[k-1];
        end
      end
    end
  end

endmodule

@@ sv/vnc_back.sv @@
// Back part: sequencer over one shared complex multiplier, accumulator and output register.
module vnc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  vnc_pkg::fifo_stat_t fstat,
  input  vnc_pkg::job_t       head,
  output logic                pop,
  vnc_out_if.source           out_m,
  output vnc_pkg::back_stat_t bstat
);

  localparam int W = vnc_pkg::W;
  localparam int XW = vnc_pkg::XW;
  localparam int PW = vnc_pkg::PW;
  localparam int TW = vnc_pkg::TW;
  localparam int AW = vnc_pkg::AW;
  localparam int OPW = vnc_pkg::OPW;
  localparam int FRAC = vnc_pkg::FRAC;
  localparam int AL_DN = (W > 16) ? W - 16 : 0;
  localparam int AL_UP = (W < 16) ? 16 - W : 0;
  localparam int ALW = W + AL_UP + 2;
  localparam longint AL_HALF = (AL_DN > 0) ? (64'sd1 <<< (AL_DN - 1)) : 64'sd0;
  localparam int FS = 2 * FRAC - (W - 1);
  localparam int FS_DN = (FS > 0) ? FS : 0;
  localparam int FS_UP = (FS < 0) ? -FS : 0;
  localparam int FW = AW + FS_UP + 2;
  localparam longint FS_HALF = (FS_DN > 0) ? (64'sd1 <<< (FS_DN - 1)) : 64'sd0;
  localparam logic signed [FW-1:0] SAT_HI = FW'((64'sd1 <<< (W - 1)) - 64'sd1);
  localparam logic signed [FW-1:0] SAT_LO = -SAT_HI - FW'(1);
  localparam logic signed [PW-1:0] P_HALF = PW'(64'sd1 <<< (FRAC - 1));

  function automatic logic signed [XW-1:0] align(input logic signed [W-1:0] v);
    logic signed [ALW-1:0] t;
    t = ALW'(v) <<< AL_UP;
    t = (t + ALW'(AL_HALF)) >>> AL_DN;
    return XW'(t);
  endfunction

  function automatic vnc_pkg::samp_t finish(input logic signed [AW-1:0] a);
    logic signed [FW-1:0] v;
    v = FW'(a) <<< FS_UP;
    v = (v + FW'(FS_HALF)) >>> FS_DN;
    if (v > SAT_HI) v = SAT_HI;
    if (v < SAT_LO) v = SAT_LO;
    return v[W-1:0];
  endfunction

  vnc_pkg::state_t     state_r, state_nxt;
  logic [OPW-1:0]      op_r, op_nxt;
  vnc_pkg::cop_t       x_r [vnc_pkg::TAPS+1];
  vnc_pkg::cop_t       sq1_r, s5_r, c5_r;
  logic signed [PW-1:0] prod_re_r, prod_im_r;
  logic signed [TW-1:0] term_re_r, term_im_r;
  logic signed [AW-1:0] acc_re_r, acc_im_r;
  logic                out_valid_r, out_valid_nxt;
  vnc_pkg::samp_t      out_re_r, out_im_r;

  vnc_pkg::cop_t       opa, opb, rnd_v;
  logic signed [PW-1:0] rnd_re_w, rnd_im_w;
  logic                out_free, load_out, start;
  vnc_pkg::samp_t      load_re, load_im;

  function automatic vnc_pkg::cop_t pick(input vnc_pkg::src_t s,
                                         input vnc_pkg::cop_t x0, input vnc_pkg::cop_t x1,
                                         input vnc_pkg::cop_t x2, input vnc_pkg::cop_t x3,
                                         input vnc_pkg::cop_t x4, input vnc_pkg::cop_t x5,
                                         input vnc_pkg::cop_t q1, input vnc_pkg::cop_t q5,
                                         input vnc_pkg::cop_t k5);
    vnc_pkg::cop_t r;
    case (s)
      vnc_pkg::SRC_X0: r = x0;
      vnc_pkg::SRC_X1: r = x1;
      vnc_pkg::SRC_X2: r = x2;
      vnc_pkg::SRC_X3: r = x3;
      vnc_pkg::SRC_X4: r = x4;
      vnc_pkg::SRC_X5: r = x5;
      vnc_pkg::SRC_SQ1: r = q1;
      vnc_pkg::SRC_S5: r = q5;
      vnc_pkg::SRC_C5: r = k5;
      default: begin
        r.re = vnc_pkg::ONE_Q15;
        r.im = '0;
      end
    endcase
    return r;
  endfunction

  assign opa = pick(vnc_pkg::op_a(op_r), x_r[0], x_r[1], x_r[2], x_r[3], x_r[4], x_r[5],
                    sq1_r, s5_r, c5_r);
  assign opb = pick(vnc_pkg::op_b(op_r), x_r[0], x_r[1], x_r[2], x_r[3], x_r[4], x_r[5],
                    sq1_r, s5_r, c5_r);

  assign rnd_re_w = (prod_re_r + P_HALF) >>> FRAC;
  assign rnd_im_w = (prod_im_r + P_HALF) >>> FRAC;
  assign rnd_v.re = XW'(rnd_re_w);
  assign rnd_v.im = XW'(rnd_im_w);

  assign out_free = !out_valid_r || out_m.ready;

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    pop = 1'b0;
    start = 1'b0;
    load_out = 1'b0;
    load_re = head.x[0].re;
    load_im = head.x[0].im;
    case (state_r)
      vnc_pkg::ST_IDLE: begin
        if (!fstat.empty && out_free) begin
          pop = 1'b1;
          if (head.pass) begin
            load_out = 1'b1;
          end else begin
            start = 1'b1;
            op_nxt = '0;
            state_nxt = vnc_pkg::ST_MUL;
          end
        end
      end
      vnc_pkg::ST_MUL: state_nxt = vnc_pkg::ST_RND;
      vnc_pkg::ST_RND: begin
        if (op_r == OPW'(vnc_pkg::NOPS - 1)) begin
          state_nxt = vnc_pkg::ST_ACC;
        end else begin
          op_nxt = op_r + 1'b1;
          state_nxt = vnc_pkg::ST_MUL;
        end
      end
      vnc_pkg::ST_ACC: state_nxt = vnc_pkg::ST_FIN;
      vnc_pkg::ST_FIN: begin
        load_re = finish(acc_re_r);
        load_im = finish(acc_im_r);
        if (out_free) begin
          load_out = 1'b1;
          state_nxt = vnc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = vnc_pkg::ST_IDLE;
    endcase
    out_valid_nxt = load_out ? 1'b1 : (out_m.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vnc_pkg::ST_IDLE;
      op_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      for (int k = 0; k <= vnc_pkg::TAPS; k++) begin
        x_r[k].re <= align(head.x[k].re);
        x_r[k].im <= align(head.x[k].im);
      end
      acc_re_r <= '0;
      acc_im_r <= '0;
      term_re_r <= '0;
      term_im_r <= '0;
    end
    if (state_r == vnc_pkg::ST_MUL) begin
      prod_re_r <= PW'(opa.re) * PW'(opb.re) - PW'(opa.im) * PW'(opb.im);
      prod_im_r <= PW'(opa.re) * PW'(opb.im) + PW'(opa.im) * PW'(opb.re);
    end
    if (state_r == vnc_pkg::ST_RND) begin
      term_re_r <= TW'(rnd_v.re) * TW'(vnc_pkg::op_coef(op_r));
      term_im_r <= TW'(rnd_v.im) * TW'(vnc_pkg::op_coef(op_r));
      case (vnc_pkg::op_dst(op_r))
        vnc_pkg::DST_SQ1: sq1_r <= rnd_v;
        vnc_pkg::DST_S5: s5_r <= rnd_v;
        vnc_pkg::DST_C5: c5_r <= rnd_v;
        default: ;
      endcase
    end
    if (state_r == vnc_pkg::ST_MUL || state_r == vnc_pkg::ST_ACC) begin
      acc_re_r <= acc_re_r + AW'(term_re_r);
      acc_im_r <= acc_im_r + AW'(term_im_r);
    end
    if (load_out) begin
      out_re_r <= load_re;
      out_im_r <= load_im;
    end
  end

  assign out_m.valid = out_valid_r;
  assign out_m.out_re = out_re_r;
  assign out_m.out_im = out_im_r;
  assign bstat.state = state_r;

endmodule

@@ sv/volterra_nonlinear_channel_core.sv @@
// Top level of the five-tap Volterra-style nonlinear complex channel.
//
// Usage: complex Q1.15 samples arrive as words on in_s (valid/ready) and leave
// as words on out_m. Each input word yields exactly one output word, in order.
// cfg_we/cfg_wdata write the nonlinear enable bit; write it only while idle.
//
// The front part accepts a word whenever the two-entry job queue has room,
// shifts the five-sample history and marks the job as pass-through while the
// enable is off or fewer than five samples have been seen since reset.
// The back part serves one job at a time. A pass-through job is popped
// straight into the output register, so its word passes from the queue
// register into the output register. A full job runs nineteen complex
// products through one shared four-multiplier unit, each in a multiply
// state and then a round-and-weight state; an accumulate state then drains
// the accumulator and a finish state rounds and saturates the sum.
// Reset (rst_n, synchronous) clears the history, warm-up count and queue,
// and sets the enable bit. When the receiver stalls, the output register
// holds its word, the back part waits and the queue fills up to two jobs
// before in_s.ready drops.
module volterra_nonlinear_channel_core (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  vnc_in_if.sink    in_s,
  vnc_out_if.source out_m
);

  vnc_pkg::fifo_stat_t fstat;
  vnc_pkg::back_stat_t bstat;
  vnc_pkg::job_t       job_in, job_head;
  logic                push, pop;

  vnc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_s      (in_s),
    .fstat     (fstat),
    .push      (push),
    .job       (job_in)
  );

  vnc_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (job_in),
    .pop   (pop),
    .dout  (job_head),
    .stat  (fstat)
  );

  vnc_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .fstat (fstat),
    .head  (job_head),
    .pop   (pop),
    .out_m (out_m),
    .bstat (bstat)
  );

  // The queue must never be written when full nor read when empty.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && fstat.full)) else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && fstat.empty)) else $error("job queue underflow");

  // A new output word comes only from a pass-through pop or a finished sum.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_m.valid) |->
      ($past(bstat.state) == vnc_pkg::ST_FIN || $past(bstat.state) == vnc_pkg::ST_IDLE))
    else $error("output word from an unexpected state");

  // A job only leaves the queue while the sequencer is idle.
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> bstat.state == vnc_pkg::ST_IDLE) else $error("pop while busy");

endmodule
